[sv/mpeg_video_sequence_header_parser_assert.svh]
// Assertion macros shared by the parser modules.
`ifndef MPEG_VIDEO_SEQUENCE_HEADER_PARSER_ASSERT_SVH
`define MPEG_VIDEO_SEQUENCE_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MVSH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define MVSH_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define MVSH_ASSERT(lbl, clk, rst, prop, msg)
`define MVSH_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

[sv/mvsh_pkg.sv]
`default_nettype none

package mvsh_pkg;

   localparam logic [7:0] CODE_SEQ_HDR = 8'hB3;
   localparam logic [7:0] CODE_SEQ_EXT = 8'hB5;

   // what a finished unit means to the back end
   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_SEQ_HDR = 2'd1,
      KIND_SEQ_EXT = 2'd2,
      KIND_OTHER   = 2'd3
   } unit_kind_type;

   // classified unit: kind plus unit bytes 4..11
   typedef struct packed {
      unit_kind_type    kind;
      logic [7:0][7:0]  bytes;
   } unit_desc_type;

   typedef struct packed {
      logic [11:0] hsize;
      logic [11:0] vsize;
      logic [3:0]  aspect;
      logic [3:0]  frame_code;
      logic [17:0] bit_rate;
      logic [9:0]  vbv;
   } pending_type;

   typedef struct packed {
      logic [13:0] horizontal_size;
      logic [13:0] vertical_size;
      logic [3:0]  aspect_code;
      logic        progressive;
      logic        interlaced;
      logic [1:0]  chroma_format;
      logic [15:0] rate_numerator;
      logic [9:0]  rate_divisor;
      logic [29:0] bit_rate;
      logic [17:0] vbv_buffer_size;
   } attr_type;

   typedef struct packed {
      logic [15:0] num;
      logic [9:0]  div;
   } rate_type;

   function automatic rate_type rate_lookup(input logic [3:0] code);
      rate_type r;
      unique case (code)
         4'd1:    r = '{num: 16'd24000, div: 10'd1001};
         4'd2:    r = '{num: 16'd24,    div: 10'd1};
         4'd3:    r = '{num: 16'd25,    div: 10'd1};
         4'd4:    r = '{num: 16'd30000, div: 10'd1001};
         4'd5:    r = '{num: 16'd30,    div: 10'd1};
         4'd6:    r = '{num: 16'd50,    div: 10'd1};
         4'd7:    r = '{num: 16'd60000, div: 10'd1001};
         4'd8:    r = '{num: 16'd60,    div: 10'd1};
         default: r = '{num: 16'd0,     div: 10'd1};
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/mvsh_channel_if.sv]
`default_nettype none

interface mvsh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source(output valid, data_byte, last_byte, input ready);
   modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface mvsh_rsp_if;
   logic        valid;
   logic        ready;
   logic        changed;
   logic        attributes_valid;
   logic [13:0] horizontal_size;
   logic [13:0] vertical_size;
   logic [3:0]  aspect_code;
   logic        progressive;
   logic        interlaced;
   logic [1:0]  chroma_format;
   logic [15:0] rate_numerator;
   logic [9:0]  rate_divisor;
   logic [29:0] bit_rate;
   logic [17:0] vbv_buffer_size;

   modport source(output valid, changed, attributes_valid, horizontal_size, vertical_size,
                  aspect_code, progressive, interlaced, chroma_format, rate_numerator,
                  rate_divisor, bit_rate, vbv_buffer_size, input ready);
   modport sink(input valid, changed, attributes_valid, horizontal_size, vertical_size,
                aspect_code, progressive, interlaced, chroma_format, rate_numerator,
                rate_divisor, bit_rate, vbv_buffer_size, output ready);
endinterface

`default_nettype wire

[sv/mpeg_video_sequence_header_parser.sv]
// MPEG video sequence header parser.
//
// req_chan carries the bytes of video units, one byte per transfer; each unit
// starts with 00 00 01 and a unit code, and last_byte marks its final byte.
// rsp_chan carries one result per unit, after the transfer of its last byte:
// the committed picture attributes plus a changed flag.
// A sequence header arms a commit; the next well-formed non-header unit commits
// MPEG-2 values when it is a sequence extension and MPEG-1 values otherwise.
// Throughput: one byte per cycle, also a last byte per cycle, with rsp_chan ready.
// After the transfer of the unit's last byte, the result passes through the
// front-to-back queue and then into the output register, which drives
// rsp_chan.valid; a stalled receiver can hold it in the queue.
// The front classifies each unit and hands it through a two-entry queue to
// the back end, which updates the pending header and commit state.
// Reset (synchronous) empties the queue, drops any result in flight, and
// clears the pending header, the wait and the committed attributes.
// When the receiver stalls, the result holds, the back end stops, the queue
// fills, and req_chan.ready drops once two closed units are waiting.
`default_nettype none

module mpeg_video_sequence_header_parser
   import mvsh_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   mvsh_req_if.sink   req_chan,
   mvsh_rsp_if.source rsp_chan
);

   logic          q_push;
   logic          q_not_full;
   logic          q_not_empty;
   logic          q_pop;
   unit_desc_type push_desc;
   unit_desc_type pop_desc;

   // front: track byte position, check the prefix, capture bytes, classify
   mvsh_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .q_ready (q_not_full),
      .q_push  (q_push),
      .q_desc  (push_desc)
   );

   // short queue so front and back stall independently
   mvsh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_desc  (pop_desc)
   );

   // back: pending header, commit, change detection, result register
   mvsh_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_not_empty),
      .q_desc  (pop_desc),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

`default_nettype wire

[sv/mvsh_front.sv]
`default_nettype none
`include "mpeg_video_sequence_header_parser_assert.svh"

module mvsh_front
   import mvsh_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   mvsh_req_if.sink      req,
   input  wire logic     q_ready,
   output logic          q_push,
   output unit_desc_type q_desc
);

   logic [3:0]      pos_ff, pos_in;
   logic            prefix_ok_ff, prefix_ok_in;
   logic [7:0]      code_ff, code_in;
   logic [7:0][7:0] bytes_ff, bytes_in;
   logic            ok_now;
   logic            accept;

   assign req.ready = q_ready;
   assign accept    = req.valid && req.ready;
   assign q_push    = accept && req.last_byte;

   always_comb begin
      code_in = (pos_ff == 4'd3) ? req.data_byte : code_ff;
      ok_now  = prefix_ok_ff;
      if (pos_ff < 4'd3) begin
         if (req.data_byte != ((pos_ff == 4'd2) ? 8'h01 : 8'h00)) begin
            ok_now = 1'b0;
         end
      end
      bytes_in = bytes_ff;
      if (pos_ff >= 4'd4 && pos_ff <= 4'd11) begin
         bytes_in[3'(pos_ff - 4'd4)] = req.data_byte;
      end
      pos_in       = req.last_byte ? 4'd0 : ((pos_ff == 4'd15) ? pos_ff : pos_ff + 4'd1);
      prefix_ok_in = req.last_byte ? 1'b1 : ok_now;
   end

   // classify the unit as it closes; count >= n is pos >= n-1
   always_comb begin
      q_desc.bytes = bytes_in;
      priority if (pos_ff < 4'd3 || !ok_now) begin
         q_desc.kind = KIND_NONE;
      end else if (code_in == CODE_SEQ_HDR && pos_ff >= 4'd11) begin
         q_desc.kind = KIND_SEQ_HDR;
      end else if (code_in == CODE_SEQ_EXT && pos_ff >= 4'd9) begin
         q_desc.kind = KIND_SEQ_EXT;
      end else begin
         q_desc.kind = KIND_OTHER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 4'd0;
         prefix_ok_ff <= 1'b1;
         code_ff      <= 8'h00;
      end else if (accept) begin
         pos_ff       <= pos_in;
         prefix_ok_ff <= prefix_ok_in;
         code_ff      <= code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bytes_ff <= bytes_in;
      end
   end

   `MVSH_ASSERT(a_front_unit_restart, clock, reset, (req.valid && req.ready && req.last_byte) |=> (pos_ff == 4'd0 && prefix_ok_ff), "front did not restart after unit end")

endmodule

`default_nettype wire

[sv/mvsh_queue.sv]
`default_nettype none
`include "mpeg_video_sequence_header_parser_assert.svh"

module mvsh_queue
   import mvsh_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire unit_desc_type push_desc,
   output logic               not_full,
   input  wire logic          pop,
   output logic               not_empty,
   output unit_desc_type      pop_desc
);

   unit_desc_type entry_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff;

   assign not_full  = count_ff != 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_desc  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   `MVSH_NEVER(a_q_count_range, clock, reset, count_ff == 2'd3, "queue count out of range")
   `MVSH_ASSERT(a_q_push_count, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1), "queue count missed a push")

endmodule

`default_nettype wire

[sv/mvsh_back.sv]
`default_nettype none
`include "mpeg_video_sequence_header_parser_assert.svh"

module mvsh_back
   import mvsh_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire unit_desc_type q_desc,
   output logic               q_pop,
   mvsh_rsp_if.source         rsp
);

   pending_type pend_ff, pend_in;
   logic        waiting_ff, waiting_in;
   attr_type    attr_ff, attr_in;
   logic        valid_ff, valid_in;
   logic        out_valid_ff;
   logic        out_changed_ff;
   logic        out_av_ff;
   attr_type    out_attr_ff;

   logic [7:0][7:0] u;
   rate_type        rate;
   attr_type        new_attr;
   logic [31:0]     f;
   logic [6:0]      ext_num;
   logic            commit;
   logic            changed;

   assign q_pop = q_valid && (!out_valid_ff || rsp.ready);
   assign u     = q_desc.bytes;
   assign f     = {u[4], u[5], u[6], u[7]};
   assign rate  = rate_lookup(pend_ff.frame_code);
   assign ext_num = {3'b000, pend_ff.frame_code} * ({5'd0, u[5][6:5]} + 7'd1);

   always_comb begin
      // MPEG-1 defaults from the pending header
      new_attr.horizontal_size = {2'b00, pend_ff.hsize};
      new_attr.vertical_size   = {2'b00, pend_ff.vsize};
      new_attr.aspect_code     = pend_ff.aspect;
      new_attr.progressive     = 1'b0;
      new_attr.interlaced      = 1'b0;
      new_attr.chroma_format   = 2'b00;
      new_attr.rate_numerator  = rate.num;
      new_attr.rate_divisor    = rate.div;
      new_attr.bit_rate        = {12'd0, pend_ff.bit_rate};
      new_attr.vbv_buffer_size = {8'd0, pend_ff.vbv};
      if (q_desc.kind == KIND_SEQ_EXT) begin
         new_attr.horizontal_size = {u[1][0], u[2][7], pend_ff.hsize};
         new_attr.vertical_size   = {u[2][6:5], pend_ff.vsize};
         new_attr.progressive     = u[1][3];
         new_attr.interlaced      = ~u[1][3];
         new_attr.chroma_format   = u[1][2:1];
         new_attr.bit_rate        = {u[2][4:0], u[3][7:1], pend_ff.bit_rate};
         new_attr.vbv_buffer_size = {u[4], pend_ff.vbv};
         if (rate.num == 16'd0) begin
            new_attr.rate_numerator = 16'(ext_num);
            new_attr.rate_divisor   = 10'({1'b0, u[5][4:0]} + 6'd1);
         end
      end
   end

   always_comb begin
      pend_in    = pend_ff;
      waiting_in = waiting_ff;
      commit     = 1'b0;
      unique case (q_desc.kind)
         KIND_NONE: begin
         end
         KIND_SEQ_HDR: begin
            pend_in.hsize      = {u[0], u[1][7:4]};
            pend_in.vsize      = {u[1][3:0], u[2]};
            pend_in.aspect     = u[3][7:4];
            pend_in.frame_code = u[3][3:0];
            pend_in.bit_rate   = f[31:14];
            pend_in.vbv        = f[12:3];
            waiting_in         = 1'b1;
         end
         KIND_SEQ_EXT, KIND_OTHER: begin
            commit = waiting_ff;
         end
         default: begin
         end
      endcase
      if (commit) waiting_in = 1'b0;
      attr_in  = commit ? new_attr : attr_ff;
      valid_in = valid_ff || commit;
      changed  = commit && (!valid_ff || new_attr != attr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         waiting_ff   <= 1'b0;
         attr_ff      <= '0;
         valid_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            pend_ff    <= pend_in;
            waiting_ff <= waiting_in;
            attr_ff    <= attr_in;
            valid_ff   <= valid_in;
         end
         if (q_pop) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_changed_ff <= changed;
         out_av_ff      <= valid_in;
         out_attr_ff    <= attr_in;
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.changed          = out_changed_ff;
   assign rsp.attributes_valid = out_av_ff;
   assign rsp.horizontal_size  = out_attr_ff.horizontal_size;
   assign rsp.vertical_size    = out_attr_ff.vertical_size;
   assign rsp.aspect_code      = out_attr_ff.aspect_code;
   assign rsp.progressive      = out_attr_ff.progressive;
   assign rsp.interlaced       = out_attr_ff.interlaced;
   assign rsp.chroma_format    = out_attr_ff.chroma_format;
   assign rsp.rate_numerator   = out_attr_ff.rate_numerator;
   assign rsp.rate_divisor     = out_attr_ff.rate_divisor;
   assign rsp.bit_rate         = out_attr_ff.bit_rate;
   assign rsp.vbv_buffer_size  = out_attr_ff.vbv_buffer_size;

   `MVSH_ASSERT(a_back_valid_sticky, clock, reset, valid_ff |=> valid_ff, "attributes valid flag dropped")
   `MVSH_ASSERT(a_back_empty_attr, clock, reset, (out_valid_ff && !out_av_ff) |-> (out_attr_ff.rate_divisor == 10'd0), "attributes before first commit not zero")

endmodule

`default_nettype wire
